/* hw/rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

	typedef enum logic [2:0] {
		PH_HDR   = 3'd0,
		PH_LEN   = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_MASK  = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	localparam logic [6:0] OP_TEXT   = 7'h01;
	localparam logic [6:0] OP_BINARY = 7'h02;
	localparam logic [6:0] OP_CLOSE  = 7'h08;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef struct packed {
		logic       hit;
		logic [7:0] data;
		logic       kind;
		logic       last;
		logic       close;
	} wsd_res_t;

endpackage

/* hw/rtl/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header parser and payload unmasker, one byte per step.
// ----------------------------------------------------------------------------
module wsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_data,
	output wsd_pkg::wsd_res_t res
);
	import wsd_pkg::*;

	phase_t      phase_q,  phase_d;
	logic [2:0]  count_q,  count_d;
	logic        fin_q,    fin_d;
	logic [6:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [31:0] key_q,    key_d;
	logic [63:0] remain_q, remain_d;
	logic [1:0]  midx_q,   midx_d;

	logic [2:0]  count_inc;
	logic [7:0]  key_byte;
	logic        len_done;

	assign count_inc = count_q + 3'd1;

	always_comb begin
		case (midx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		fin_d    = fin_q;
		opcode_d = opcode_q;
		masked_d = masked_q;
		key_d    = key_q;
		remain_d = remain_q;
		midx_d   = midx_q;
		len_done = 1'b0;
		res      = '0;

		case (phase_q)
			PH_LEN: begin
				masked_d = rx_data[7];
				midx_d   = 2'd0;
				key_d    = '0;
				count_d  = 3'd0;
				if (rx_data[6:0] == LEN_EXT16) begin
					remain_d = '0;
					phase_d  = PH_EXT16;
				end else if (rx_data[6:0] == LEN_EXT64) begin
					remain_d = '0;
					phase_d  = PH_EXT64;
				end else begin
					remain_d = {57'd0, rx_data[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXT16, PH_EXT64: begin
				remain_d = {remain_q[55:0], rx_data};
				count_d  = count_inc;
				if ((phase_q == PH_EXT16 && count_inc == 3'd2) ||
				    (phase_q == PH_EXT64 && count_inc == 3'd0)) begin
					len_done = 1'b1;
				end
			end
			PH_MASK: begin
				key_d   = {key_q[23:0], rx_data};
				count_d = count_inc;
				if (count_inc[2]) begin
					count_d = 3'd0;
					phase_d = (remain_q == 64'd0) ? PH_HDR : PH_DATA;
				end
			end
			PH_DATA: begin
				if (fin_q && (opcode_q == OP_TEXT || opcode_q == OP_BINARY)) begin
					res.hit  = 1'b1;
					res.data = rx_data ^ (masked_q ? key_byte : 8'd0);
					res.kind = (opcode_q == OP_BINARY);
					res.last = (remain_q == 64'd1);
				end
				midx_d   = midx_q + 2'd1;
				remain_d = remain_q - 64'd1;
				if (remain_q == 64'd1) begin
					phase_d = PH_HDR;
				end
			end
			default: begin
				fin_d    = rx_data[7];
				opcode_d = rx_data[6:0];
				count_d  = 3'd0;
				phase_d  = PH_LEN;
				if (rx_data[7] && rx_data[6:0] == OP_CLOSE) begin
					res.hit   = 1'b1;
					res.close = 1'b1;
				end
			end
		endcase

		// length complete: go to mask key, payload or next header
		if (len_done) begin
			count_d = 3'd0;
			if (masked_d) begin
				phase_d = PH_MASK;
			end else if (remain_d == 64'd0) begin
				phase_d = PH_HDR;
			end else begin
				phase_d = PH_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			count_q  <= '0;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			masked_q <= 1'b0;
			key_q    <= '0;
			remain_q <= '0;
			midx_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			key_q    <= key_d;
			remain_q <= remain_d;
			midx_q   <= midx_d;
		end
	end

endmodule

/* hw/rtl/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Client websocket frame parser: unmasked text and binary payload bytes
// and close events from a received byte stream.
// ----------------------------------------------------------------------------
// pipeline: input register, then result register; bytes with no result
// are absorbed silently
// throughput: one byte per cycle while a held result is not stalled by out_ready
// reset: arst_n clears the pipeline valids and returns the parser to
// waiting for a frame header
module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_kind,
	output logic       last_byte,
	output logic       event_res
);
	import wsd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       slot_free;
	logic       adv_s1;
	wsd_res_t   res;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       kind_q;
	logic       last_q;
	logic       close_q;

	assign slot_free = !out_valid_q || out_ready;
	assign adv_s1    = valid_s1 && slot_free;
	assign in_ready  = !valid_s1 || slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.rx_data (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res.hit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.hit) begin
			out_byte_q <= res.data;
			kind_q     <= res.kind;
			last_q     <= res.last;
			close_q    <= res.close;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign frame_kind = kind_q;
	assign last_byte  = last_q;
	assign event_res  = close_q;

	a_close_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res |-> out_byte == 8'd0 && !frame_kind && !last_byte)
		else $error("close event with nonzero payload fields");

	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");

	a_hit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res.hit |=> out_valid)
		else $error("parser result lost");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 && !out_valid |=> !out_valid)
		else $error("result appeared without a parser step");

endmodule

/* sim/tb_websocket_frame_deframer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Streams client websocket frames into the deframer byte by byte, tracks the
// parser state alongside it and checks every unmasked payload byte and close
// event in order, under random idling, long output stalls and drain pauses.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
	import wsd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       kind;
		logic       last;
		logic       close;
	} ws_res_t;

	typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       frame_kind;
	logic       last_byte;
	logic       event_res;

	// parser shadow state
	phase_t      ph;
	logic [2:0]  hdr_cnt;
	logic        fin;
	logic [6:0]  opcode;
	logic        mask_on;
	logic [31:0] key;
	logic [63:0] remain;
	logic [1:0]  key_idx;

	ws_res_t expected_q[$];
	int      mismatch_cnt = 0;
	int      sent_cnt = 0;
	bit      tx_idle_en = 0;
	bit      rx_idle_en = 0;
	int      hold_reqs = 0;

	websocket_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.frame_kind(frame_kind),
		.last_byte (last_byte),
		.event_res (event_res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void end_of_length();
		hdr_cnt = 3'd0;
		if (mask_on) begin
			ph = PH_MASK;
		end else if (remain == 64'd0) begin
			ph = PH_HDR;
		end else begin
			ph = PH_DATA;
		end
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		ws_res_t    r;
		logic [7:0] k;
		case (ph)
			PH_LEN: begin
				mask_on = b[7];
				key_idx = 2'd0;
				key     = 32'd0;
				hdr_cnt = 3'd0;
				if (b[6:0] == LEN_EXT16) begin
					remain = 64'd0;
					ph     = PH_EXT16;
				end else if (b[6:0] == LEN_EXT64) begin
					remain = 64'd0;
					ph     = PH_EXT64;
				end else begin
					remain = 64'(b[6:0]);
					end_of_length();
				end
			end
			PH_EXT16, PH_EXT64: begin
				remain  = {remain[55:0], b};
				hdr_cnt = hdr_cnt + 3'd1;
				if ((ph == PH_EXT16 && hdr_cnt == 3'd2) ||
						(ph == PH_EXT64 && hdr_cnt == 3'd0))
					end_of_length();
			end
			PH_MASK: begin
				key     = {key[23:0], b};
				hdr_cnt = hdr_cnt + 3'd1;
				if (hdr_cnt >= 3'd4) begin
					hdr_cnt = 3'd0;
					ph      = (remain == 64'd0) ? PH_HDR : PH_DATA;
				end
			end
			PH_DATA: begin
				if (fin && (opcode == OP_TEXT || opcode == OP_BINARY)) begin
					k       = mask_on ? 8'(key >> (24 - 8 * int'(key_idx))) : 8'd0;
					r.data  = b ^ k;
					r.kind  = (opcode == OP_BINARY);
					r.last  = (remain == 64'd1);
					r.close = 1'b0;
					expected_q.push_back(r);
				end
				key_idx = key_idx + 2'd1;
				remain  = remain - 64'd1;
				if (remain == 64'd0)
					ph = PH_HDR;
			end
			default: begin
				fin     = b[7];
				opcode  = b[6:0];
				hdr_cnt = 3'd0;
				ph      = PH_LEN;
				if (fin && opcode == OP_CLOSE) begin
					r = '{data: 8'd0, kind: 1'b0, last: 1'b0, close: 1'b1};
					expected_q.push_back(r);
				end
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		predict_byte(b);
		sent_cnt++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_frame(input logic [7:0] head, input logic masked,
			input len_form_t form, input int len);
		logic [63:0] len64;
		len64 = 64'(len);
		send_byte(head);
		case (form)
			FORM_SHORT: send_byte({masked, 7'(len)});
			FORM_EXT16: begin
				send_byte({masked, LEN_EXT16});
				send_byte(len64[15:8]);
				send_byte(len64[7:0]);
			end
			default: begin
				send_byte({masked, LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					send_byte(len64[8*i +: 8]);
			end
		endcase
		if (masked)
			repeat (4) send_byte(8'($urandom));
		repeat (len) send_byte(8'($urandom));
	endtask

	task automatic random_frame();
		logic [7:0] head;
		int         sel;
		int         len;
		len_form_t  form;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			head = {1'b1, sel[0] ? OP_BINARY : OP_TEXT};
		end else if (sel == 6) begin
			head = {1'b1, OP_CLOSE};
		end else begin
			head = 8'($urandom);
		end
		sel = $urandom_range(0, 9);
		if (sel < 7) begin
			form = FORM_SHORT;
			len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 125)
				: $urandom_range(0, 12);
		end else if (sel < 9) begin
			form = FORM_EXT16;
			len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 300)
				: $urandom_range(0, 40);
		end else begin
			form = FORM_EXT64;
			len  = $urandom_range(0, 40);
		end
		send_frame(head, $urandom_range(0, 9) < 7, form, len);
	endtask

	task automatic test_directed_frames();
		logic [7:0] seq[] = '{
			8'h81, 8'h01, 8'hff,
			8'h88, 8'h00,
			8'hc1, 8'h00,
			8'h82, 8'hfe, 8'h00, 8'h01, 8'ha5, 8'h5a, 8'h00, 8'hff, 8'hff,
			8'h81, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00
		};
		foreach (seq[i])
			send_byte(seq[i]);
		wait_drain();
	endtask

	task automatic test_random_frames(input int target);
		while (sent_cnt < target)
			random_frame();
	endtask

	task automatic test_output_backpressure();
		hold_reqs++;
		send_frame({1'b1, OP_TEXT}, 1'b0, FORM_EXT16, 150);
		wait_drain();
	endtask

	task automatic test_sender_pause();
		repeat (6) begin
			random_frame();
			wait_drain();
		end
	endtask

	// receiver side ready with stall bursts and a long counted hold
	initial begin
		int stall_left;
		int hold_left;
		int hold_seen;
		stall_left = 0;
		hold_left  = 0;
		hold_seen  = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		ws_res_t want;
		ws_res_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{data: out_byte, kind: frame_kind, last: last_byte, close: event_res};
			if (expected_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: unexpected transfer data=%h kind=%0d last=%0d close=%0d",
						$realtime, got.data, got.kind, got.last, got.close);
			end else begin
				want = expected_q.pop_front();
				if (got.data !== want.data || got.kind !== want.kind ||
						got.last !== want.last || got.close !== want.close) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display({"%0t: mismatch expected data=%h kind=%0d last=%0d close=%0d,",
							" got data=%h kind=%0d last=%0d close=%0d"},
							$realtime, want.data, want.kind, want.last, want.close,
							got.data, got.kind, got.last, got.close);
				end
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_byte   = 8'd0;
		ph        = PH_HDR;
		hdr_cnt   = 3'd0;
		fin       = 1'b0;
		opcode    = 7'd0;
		mask_on   = 1'b0;
		key       = 32'd0;
		remain    = 64'd0;
		key_idx   = 2'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_frames();
		tx_idle_en = 1;
		rx_idle_en = 1;
		test_random_frames(1000);
		test_output_backpressure();
		test_sender_pause();
		tx_idle_en = 0;
		rx_idle_en = 0;
		test_random_frames(1750);
		wait_drain();
		repeat (6) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
